// ===== sv/access_pattern_policy_selector_defines.svh =====
// Assertion macros for the file that checks its own logic.
`ifndef ACCESS_PATTERN_POLICY_SELECTOR_DEFINES_SVH
`define ACCESS_PATTERN_POLICY_SELECTOR_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled during reset.
`define APPS_ASSERT_NOW(lbl, lhs, rhs) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// Next-cycle implication, checked on clk and disabled during reset.
`define APPS_ASSERT_NEXT(lbl, lhs, rhs) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

// ===== sv/apps_pkg.sv =====
package apps_pkg;

    localparam int SEEN_ENTRIES_DEF = 4096;
    localparam int KEY_W = 64;
    localparam int CNT_W = 32;

    localparam logic [2:0] PAT_UNKNOWN = 3'd0;
    localparam logic [2:0] PAT_MRU     = 3'd1;
    localparam logic [2:0] PAT_LRU     = 3'd2;
    localparam logic [2:0] PAT_FIFO    = 3'd3;
    localparam logic [2:0] PAT_S3FIFO  = 3'd4;

    localparam logic [1:0] POL_FIFO   = 2'd0;
    localparam logic [1:0] POL_MRU    = 2'd1;
    localparam logic [1:0] POL_MGLRU  = 2'd2;
    localparam logic [1:0] POL_S3FIFO = 2'd3;

    localparam logic [1:0] REG_MIN_SWITCH = 2'd0;
    localparam logic [1:0] REG_MIN_EVENTS = 2'd1;
    localparam logic [1:0] REG_RECENT     = 2'd2;
    localparam logic [1:0] REG_SLACK      = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] seq;
        logic [CNT_W-1:0] reacc;
        logic [CNT_W-1:0] recent;
        logic [CNT_W-1:0] hits;
    } stats_t;

    function automatic logic [1:0] policy_for(input logic [2:0] pat);
        logic [1:0] pol;
        case (pat)
            PAT_MRU:  pol = POL_MRU;
            PAT_LRU:  pol = POL_MGLRU;
            PAT_FIFO: pol = POL_FIFO;
            default:  pol = POL_S3FIFO;
        endcase
        return pol;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

// ===== sv/access_pattern_policy_selector.sv =====
// Access-pattern policy selector.
// Input channel (in_valid/in_ready) takes one beat per item: opcode 0 records
// a page access, opcode 1 classifies the statistics and may switch policy.
// Output channel (out_valid/out_ready) carries one beat per classify item and
// none per record item; the result sits in an output register, so the core
// returns to idle while it waits to be taken.
// A record item hashes the key, then probes slots of the seen-key memory
// (one read then one compare per slot) and ends with a write-back; a
// classify item runs the classifier, then waits for a free output register.
// After reset, and after every policy switch, a clearing pass writes every
// entry of the seen-key memory, one per cycle; no item
// is accepted meanwhile. Configuration writes are taken at any time but are
// meant for an idle block. If the receiver stalls, a second classify result
// waits in the core, which then accepts no further item.
// SEEN_ENTRIES must be a power of two.
`include "access_pattern_policy_selector_defines.svh"
module access_pattern_policy_selector #(
    parameter int SEEN_ENTRIES = apps_pkg::SEEN_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [31:0] device_id,
    input  logic [63:0] inode_number,
    input  logic [63:0] page_offset,
    input  logic        seq_hint,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  pattern_code,
    output logic [1:0]  policy_code,
    output logic        switched,
    output logic [15:0] switch_total
);

    localparam int AW = $clog2(SEEN_ENTRIES);
    localparam int CW = apps_pkg::CNT_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_HASH1 = 4'd1;
    localparam logic [3:0] ST_HASH2 = 4'd2;
    localparam logic [3:0] ST_RD    = 4'd3;
    localparam logic [3:0] ST_CHK   = 4'd4;
    localparam logic [3:0] ST_WR    = 4'd5;
    localparam logic [3:0] ST_CLS   = 4'd6;
    localparam logic [3:0] ST_DEC   = 4'd7;
    localparam logic [3:0] ST_CLEAR = 4'd8;

    logic [3:0]  state_reg, state_next;

    logic [31:0] min_switch_reg;
    logic [15:0] min_events_reg, recent_reg, slack_reg;

    logic        op_reg, seq_reg;
    logic [31:0] dev_reg, now_reg;
    logic [63:0] ino_reg, pg_reg, key_reg;
    logic [63:0] key_next;

    logic [AW-1:0] start_reg, addr_reg, slot_reg, clr_reg;

    apps_pkg::stats_t stats_reg;
    logic [CW-1:0] unique_reg, wse_reg;
    logic [1:0]    policy_reg;
    logic [31:0]   last_sw_reg;
    logic [15:0]   sw_cnt_reg;

    logic        out_valid_reg, switched_reg;
    logic [2:0]  pattern_out_reg;
    logic [1:0]  policy_out_reg;
    logic [15:0] total_out_reg;

    apps_pkg::entry_t rd_entry, wr_entry;
    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr;
    logic [2:0]       pattern;

    logic          hit, found, wrap;
    logic [AW-1:0] addr_inc;
    logic [CW-1:0] total_inc, unique_n;
    logic [CW:0]   reuse_gap, ws_limit;
    logic [1:0]    cand_policy;
    logic          do_switch, out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    apps_seen_mem #(
        .DEPTH (SEEN_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (wr_entry),
        .re    (mem_re),
        .raddr (addr_reg),
        .rdata (rd_entry)
    );

    apps_classify u_cls (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (state_reg == ST_CLS),
        .stats      (stats_reg),
        .min_events (min_events_reg),
        .pattern    (pattern)
    );

    always_comb
    begin
        key_next  = (key_reg << 5) - key_reg + pg_reg;
        addr_inc  = (addr_reg == AW'(SEEN_ENTRIES - 1)) ? '0 : addr_reg + 1'b1;
        hit       = rd_entry.valid && (rd_entry.key == key_reg);
        wrap      = (addr_inc == start_reg);
        found     = hit || !rd_entry.valid || wrap;
        total_inc = apps_pkg::sat_inc(stats_reg.total);
        reuse_gap = {1'b0, total_inc} - {1'b0, rd_entry.stamp};
        ws_limit  = {1'b0, wse_reg} + (CW + 1)'(slack_reg);
        unique_n  = hit ? unique_reg : apps_pkg::sat_inc(unique_reg);
        cand_policy = apps_pkg::policy_for(pattern);
        do_switch = (pattern != apps_pkg::PAT_UNKNOWN) && (cand_policy != policy_reg)
                    && ((now_reg - last_sw_reg) >= min_switch_reg);

        mem_re    = (state_reg == ST_RD);
        mem_we    = (state_reg == ST_WR) || (state_reg == ST_CLEAR);
        mem_waddr = (state_reg == ST_CLEAR) ? clr_reg : slot_reg;
        wr_entry  = '0;
        if (state_reg == ST_WR)
        begin
            wr_entry.valid = 1'b1;
            wr_entry.key   = key_reg;
            wr_entry.stamp = stats_reg.total;
        end

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = opcode ? ST_CLS : ST_HASH1;
            ST_HASH1: state_next = ST_HASH2;
            ST_HASH2: state_next = ST_RD;
            ST_RD:    state_next = ST_CHK;
            ST_CHK:   state_next = found ? ST_WR : ST_RD;
            ST_WR:    state_next = ST_IDLE;
            ST_CLS:   state_next = ST_DEC;
            ST_DEC:   if (out_free) state_next = do_switch ? ST_CLEAR : ST_IDLE;
            ST_CLEAR: if (clr_reg == AW'(SEEN_ENTRIES - 1)) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_switch_reg <= 32'd2000;
            min_events_reg <= 16'd100;
            recent_reg     <= 16'd1000;
            slack_reg      <= 16'd500;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                apps_pkg::REG_MIN_SWITCH: min_switch_reg <= cfg_wdata;
                apps_pkg::REG_MIN_EVENTS: min_events_reg <= cfg_wdata[15:0];
                apps_pkg::REG_RECENT:     recent_reg     <= cfg_wdata[15:0];
                apps_pkg::REG_SLACK:      slack_reg      <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Item payload and key hashing; x*31 is formed as (x << 5) - x.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            op_reg  <= opcode;
            dev_reg <= device_id;
            ino_reg <= inode_number;
            pg_reg  <= page_offset;
            seq_reg <= seq_hint;
            now_reg <= now_ms;
        end
        if (state_reg == ST_HASH1)
            key_reg <= (64'(dev_reg) << 5) - 64'(dev_reg) + ino_reg;
        if (state_reg == ST_HASH2)
            key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            start_reg       <= '0;
            addr_reg        <= '0;
            slot_reg        <= '0;
            stats_reg       <= '0;
            unique_reg      <= '0;
            wse_reg         <= '0;
            policy_reg      <= apps_pkg::POL_S3FIFO;
            last_sw_reg     <= '0;
            sw_cnt_reg      <= '0;
            out_valid_reg   <= 1'b0;
            switched_reg    <= 1'b0;
            pattern_out_reg <= apps_pkg::PAT_UNKNOWN;
            policy_out_reg  <= apps_pkg::POL_S3FIFO;
            total_out_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (state_reg == ST_HASH2)
            begin
                start_reg <= key_next[AW-1:0];
                addr_reg  <= key_next[AW-1:0];
            end

            if (state_reg == ST_CHK)
            begin
                if (found)
                begin
                    // A full wrap lands back on the start slot as a new page.
                    slot_reg        <= hit ? addr_reg : (wrap && rd_entry.valid ? start_reg
                                                                               : addr_reg);
                    stats_reg.total <= total_inc;
                    if (seq_reg)
                        stats_reg.seq <= apps_pkg::sat_inc(stats_reg.seq);
                    if (hit)
                    begin
                        stats_reg.reacc <= apps_pkg::sat_inc(stats_reg.reacc);
                        if (reuse_gap < (CW + 1)'(recent_reg))
                            stats_reg.recent <= apps_pkg::sat_inc(stats_reg.recent);
                        if (reuse_gap < ws_limit)
                            stats_reg.hits <= apps_pkg::sat_inc(stats_reg.hits);
                    end
                    unique_reg <= unique_n;
                    if (unique_n != '0)
                        wse_reg <= unique_n >> 2;
                end
                else
                begin
                    addr_reg <= addr_inc;
                end
            end

            if (state_reg == ST_DEC && out_free)
            begin
                out_valid_reg   <= 1'b1;
                pattern_out_reg <= pattern;
                switched_reg    <= do_switch;
                policy_out_reg  <= do_switch ? cand_policy : policy_reg;
                total_out_reg   <= (do_switch && sw_cnt_reg != '1) ? sw_cnt_reg + 1'b1
                                                                  : sw_cnt_reg;
                if (do_switch)
                begin
                    policy_reg  <= cand_policy;
                    last_sw_reg <= now_reg;
                    if (sw_cnt_reg != '1)
                        sw_cnt_reg <= sw_cnt_reg + 1'b1;
                    stats_reg  <= '0;
                    unique_reg <= '0;
                    wse_reg    <= '0;
                    clr_reg    <= '0;
                end
            end

            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pattern_code = pattern_out_reg;
    assign policy_code  = policy_out_reg;
    assign switched     = switched_reg;
    assign switch_total = total_out_reg;

    `APPS_ASSERT_NOW(a_switch_has_pattern, out_valid && switched, pattern_code != 3'd0)
    `APPS_ASSERT_NOW(a_no_accept_in_clear, state_reg == ST_CLEAR, !in_ready)
    `APPS_ASSERT_NEXT(a_switch_starts_clear, state_reg == ST_DEC && out_free && do_switch, state_reg == ST_CLEAR)
    `APPS_ASSERT_NOW(a_record_only_path, state_reg == ST_CHK || state_reg == ST_RD, !op_reg)

endmodule

// ===== sv/apps_seen_mem.sv =====
module apps_seen_mem #(
    parameter int DEPTH = apps_pkg::SEEN_ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  apps_pkg::entry_t      wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output apps_pkg::entry_t      rdata
);

    apps_pkg::entry_t mem [DEPTH];
    apps_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/apps_classify.sv =====
module apps_classify (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  apps_pkg::stats_t            stats,
    input  logic [15:0]                 min_events,
    output logic [2:0]                  pattern
);

    localparam int PW = apps_pkg::CNT_W + 8;

    logic [PW-1:0] t, s, r, rc, h;
    logic          few, seq_hi, fifo_ok, s3_ok, mru_ok, lru_ok;
    logic [2:0]    pattern_next;
    logic [2:0]    pattern_reg;

    always_comb
    begin
        t  = PW'(stats.total);
        s  = PW'(stats.seq);
        r  = PW'(stats.reacc);
        rc = PW'(stats.recent);
        h  = PW'(stats.hits);
        few     = stats.total < apps_pkg::CNT_W'(min_events);
        seq_hi  = s * PW'(100) > t * PW'(70);
        fifo_ok = r * PW'(100) < t * PW'(15);
        s3_ok   = r * PW'(100) < t * PW'(35);
        mru_ok  = (rc << 1) > r && r * PW'(10) > (t << 1);
        lru_ok  = h * PW'(10) > r * PW'(6) && r * PW'(10) > t * PW'(3);
        if (few)
            pattern_next = apps_pkg::PAT_UNKNOWN;
        else if (seq_hi && fifo_ok)
            pattern_next = apps_pkg::PAT_FIFO;
        else if (seq_hi && s3_ok)
            pattern_next = apps_pkg::PAT_S3FIFO;
        else if (mru_ok)
            pattern_next = apps_pkg::PAT_MRU;
        else if (lru_ok)
            pattern_next = apps_pkg::PAT_LRU;
        else
            pattern_next = apps_pkg::PAT_S3FIFO;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pattern_reg <= apps_pkg::PAT_UNKNOWN;
        else if (start)
            pattern_reg <= pattern_next;
    end

    assign pattern = pattern_reg;

endmodule
